// ===== src/assert_macros.svh =====
// Assertion macros used by the top level to check the design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define RPN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition in one cycle is followed by another in the next cycle.
`define RPN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/rpn_pkg.sv =====
// Constants, codes and interface types shared by the RPN evaluator modules.
package rpn_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int DATA_W      = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);

  localparam logic [2:0] OP_PUSH = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;
  localparam logic [2:0] OP_END  = 3'd5;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_UNDER   = 3'd1;
  localparam logic [2:0] ST_DIVZERO = 3'd2;
  localparam logic [2:0] ST_BADSIZE = 3'd3;
  localparam logic [2:0] ST_OVER    = 3'd4;

  typedef struct packed {
    logic       push;
    logic       rd;
    logic       alu_ld;
    logic [2:0] alu_op;
    logic       div_start;
    logic       div_ld;
    logic       set_err;
    logic [2:0] err_code;
    logic       clear;
    logic       out_ld;
    logic       out_end;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [2:0]       err;
    logic             top_zero;
    logic             div_done;
  } stat_t;

endpackage

// ===== src/rpn_stack_evaluator.sv =====
// Top level of the reverse Polish integer expression evaluator.
// Each input beat carries one token: a push of a signed 32-bit number, an add, subtract,
// multiply or divide, or an end of expression; every beat returns exactly one result beat
// with the sticky error status, the stack top (or final result) and a flag on end beats.
// Pushes, end beats, underflows, unused codes and tokens ignored after an error load the
// result register in the accepting cycle. For add, subtract and multiply, that cycle
// starts the registered read of the second operand from the stack memory, which holds
// every entry below the top while the top sits in a register; S_EXEC computes the new
// top and S_FIN loads the result register. A divide starts the divider (one quotient bit
// per cycle) in S_EXEC and loads its quotient as the new top in S_DIVW; a divide by zero
// goes to S_FIN. A new beat is taken only when the output register is empty or emptied
// in the same cycle, so every cycle the receiver holds off is added to the next beat.
`include "assert_macros.svh"

module rpn_stack_evaluator
  import rpn_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [2:0]  in_tuser,   // [2:0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] top_value
  output logic [2:0]  out_tuser,  // [2:0] status
  output logic        out_tlast
);

  cmd_t  cmd;
  stat_t stat;

  rpn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_op     (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rpn_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_value  (in_tdata),
    .stat      (stat),
    .out_status(out_tuser),
    .out_top   (out_tdata),
    .out_done  (out_tlast)
  );

  `RPN_ASSERT(a_count_range, stat.count <= CNT_W'(STACK_DEPTH), "Stack count beyond depth.")
  `RPN_ASSERT(a_div_nonzero, !cmd.div_start || !stat.top_zero, "Divider started on zero.")
  `RPN_ASSERT_NEXT(a_end_clears, in_tvalid && in_tready && (in_tuser == OP_END), (stat.count == '0) && (stat.err == ST_OK) && out_tvalid && out_tlast, "End beat did not clear the stack.")

endmodule

// ===== src/rpn_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module rpn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/rpn_div.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module rpn_div
  import rpn_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output logic              done,
  output logic [DATA_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DATA_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              neg_r, neg_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] quo_r, quo_nxt;
  logic [DATA_W-1:0] dvs_r, dvs_nxt;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W+1:0] diff;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    neg_nxt  = neg_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    rem_sh   = {rem_r, quo_r[DATA_W-1]};
    diff     = {1'b0, rem_sh} - {2'b00, dvs_r};
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      neg_nxt  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
      rem_nxt  = '0;
      quo_nxt  = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
      dvs_nxt  = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
    end else if (busy_r) begin
      step_nxt = step_r + 1'b1;
      if (!diff[DATA_W+1]) begin
        rem_nxt = diff[DATA_W-1:0];
        quo_nxt = {quo_r[DATA_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DATA_W-1:0];
        quo_nxt = {quo_r[DATA_W-2:0], 1'b0};
      end
      if (step_r == STEP_W'(DATA_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    neg_r  <= neg_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    dvs_r  <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? (~quo_r + 1'b1) : quo_r;

endmodule

// ===== src/rpn_datapath.sv =====
// Stack storage, arithmetic unit, error register and result register of the evaluator.
module rpn_datapath
  import rpn_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  input  logic [DATA_W-1:0] in_value,
  output stat_t             stat,
  output logic [2:0]        out_status,
  output logic [DATA_W-1:0] out_top,
  output logic              out_done
);

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [2:0]        err_r, err_nxt;
  logic [DATA_W-1:0] top_r, top_nxt;
  logic [2:0]        out_status_r, out_status_nxt;
  logic [DATA_W-1:0] out_top_r, out_top_nxt;
  logic              out_done_r, out_done_nxt;
  logic [CNT_W-1:0]  count_m1;
  logic [CNT_W-1:0]  count_m2;
  logic [DATA_W-1:0] second;
  logic [DATA_W-1:0] alu_res;
  logic [DATA_W-1:0] quotient;
  logic              div_done;

  assign count_m1 = count_r - CNT_W'(1);
  assign count_m2 = count_r - CNT_W'(2);

  rpn_ram #(
    .WIDTH(DATA_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (cmd.push && (count_r != '0)),
    .waddr(count_m1[ADDR_W-1:0]),
    .wdata(top_r),
    .re   (cmd.rd),
    .raddr(count_m2[ADDR_W-1:0]),
    .rdata(second)
  );

  rpn_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .dividend(second),
    .divisor (top_r),
    .done    (div_done),
    .quotient(quotient)
  );

  always_comb begin
    case (cmd.alu_op)
      OP_ADD:  alu_res = second + top_r;
      OP_SUB:  alu_res = second - top_r;
      OP_MUL:  alu_res = second * top_r;
      default: alu_res = second;
    endcase
  end

  always_comb begin
    count_nxt      = count_r;
    err_nxt        = err_r;
    top_nxt        = top_r;
    out_status_nxt = out_status_r;
    out_top_nxt    = out_top_r;
    out_done_nxt   = out_done_r;
    if (cmd.push) begin
      top_nxt   = in_value;
      count_nxt = count_r + CNT_W'(1);
    end
    if (cmd.alu_ld) begin
      top_nxt   = alu_res;
      count_nxt = count_m1;
    end
    if (cmd.div_ld) begin
      top_nxt   = quotient;
      count_nxt = count_m1;
    end
    if (cmd.set_err) begin
      err_nxt = cmd.err_code;
    end
    if (cmd.clear) begin
      count_nxt = '0;
      err_nxt   = ST_OK;
    end
    if (cmd.out_ld) begin
      if (cmd.out_end) begin
        out_done_nxt = 1'b1;
        if (err_r != ST_OK) begin
          out_status_nxt = err_r;
          out_top_nxt    = '0;
        end else if (count_r == CNT_W'(1)) begin
          out_status_nxt = ST_OK;
          out_top_nxt    = top_r;
        end else begin
          out_status_nxt = ST_BADSIZE;
          out_top_nxt    = '0;
        end
      end else begin
        out_done_nxt   = 1'b0;
        out_status_nxt = err_nxt;
        out_top_nxt    = (count_nxt != '0) ? top_nxt : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      err_r   <= ST_OK;
    end else begin
      count_r <= count_nxt;
      err_r   <= err_nxt;
    end
    top_r        <= top_nxt;
    out_status_r <= out_status_nxt;
    out_top_r    <= out_top_nxt;
    out_done_r   <= out_done_nxt;
  end

  assign stat.count    = count_r;
  assign stat.err      = err_r;
  assign stat.top_zero = (top_r == '0);
  assign stat.div_done = div_done;

  assign out_status = out_status_r;
  assign out_top    = out_top_r;
  assign out_done   = out_done_r;

endmodule

// ===== src/rpn_ctrl.sv =====
// Controller state machine that sequences each item and owns both handshakes.
module rpn_ctrl
  import rpn_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [2:0] in_op,
  output logic       out_tvalid,
  input  logic       out_tready,
  input  stat_t      stat,
  output cmd_t       cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DIVW = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [2:0] op_r, op_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && slot_free;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cmd       = '0;
    cmd.alu_op = op_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          if (in_op == OP_END) begin
            cmd.out_ld  = 1'b1;
            cmd.out_end = 1'b1;
            cmd.clear   = 1'b1;
          end else if ((stat.err != ST_OK) || (in_op > OP_END)) begin
            cmd.out_ld = 1'b1;
          end else if (in_op == OP_PUSH) begin
            cmd.out_ld = 1'b1;
            if (stat.count >= CNT_W'(STACK_DEPTH)) begin
              cmd.set_err  = 1'b1;
              cmd.err_code = ST_OVER;
            end else begin
              cmd.push = 1'b1;
            end
          end else if (stat.count < CNT_W'(2)) begin
            cmd.out_ld   = 1'b1;
            cmd.set_err  = 1'b1;
            cmd.err_code = ST_UNDER;
          end else begin
            cmd.rd    = 1'b1;
            op_nxt    = in_op;
            state_nxt = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        if (op_r == OP_DIV) begin
          if (stat.top_zero) begin
            cmd.set_err  = 1'b1;
            cmd.err_code = ST_DIVZERO;
            state_nxt    = S_FIN;
          end else begin
            cmd.div_start = 1'b1;
            state_nxt     = S_DIVW;
          end
        end else begin
          cmd.alu_ld = 1'b1;
          state_nxt  = S_FIN;
        end
      end
      S_DIVW: begin
        if (stat.div_done) begin
          cmd.div_ld = 1'b1;
          state_nxt  = S_FIN;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = (out_valid_r && !out_tready) || cmd.out_ld;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r <= op_nxt;
  end

  assign out_tvalid = out_valid_r;

endmodule
